// ----- design/omni_wheel_odometry_top_defines.svh -----
// ----------------------------------------------------------------------------
// omni_wheel_odometry_top_defines
// Assertion macros shared by the odometry checker.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_ODOMETRY_TOP_DEFINES_SVH
`define OMNI_WHEEL_ODOMETRY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define OWO_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OWO_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/owo_pkg.sv -----
// ----------------------------------------------------------------------------
// owo_pkg
// Widths, register indexes and angle tables of the omni wheel odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package owo_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POS_FRAC_BITS_DEF = 16;

    localparam int CNT_W  = 32;
    localparam int HDG_W  = 16;
    localparam int POS_W  = 48;
    localparam int GAIN_W = 32;
    localparam int IN_W   = 4 * CNT_W + HDG_W;
    localparam int OUT_W  = 2 * POS_W + HDG_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0100_0000;

    // fraction bits carried through the rotation
    localparam int GUARD = 16;

    // 1/K of the CORDIC, Q0.32
    localparam logic [31:0] INV_K = 32'd2608131496;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- design/omni_wheel_odometry_top.sv -----
// ----------------------------------------------------------------------------
// omni_wheel_odometry_top
// Each word passes one load step, ANGLE_BITS CORDIC passes, one magnitude
// step, the multiply steps on the shared 32x32 multiplier and one
// accumulate step on its way to the result word. A new input word is
// taken only once the last one has left the accumulate step; a pending
// result word does not block the next input, but a stalled result holds
// the next item in its accumulate step. Reset (aresetn low, synchronous)
// sets the gain to 1.0, the position to zero and the previous counts to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_odometry_top #(
    parameter int ANGLE_BITS    = owo_pkg::ANGLE_BITS_DEF,
    parameter int POS_FRAC_BITS = owo_pkg::POS_FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // wheel1_count, wheel2_count, wheel3_count, wheel4_count, heading
    input  wire logic [owo_pkg::IN_W-1:0]          s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // position_x, position_y, heading_out
    output logic [owo_pkg::OUT_W-1:0]              m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [owo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [owo_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW     = owo_pkg::CNT_W;
    localparam int HW     = owo_pkg::HDG_W;
    localparam int PW     = owo_pkg::POS_W;
    localparam int XW     = 54;
    localparam int ZW     = 34;
    localparam int MW     = 53;
    localparam int TW     = 48;
    localparam int DW     = PW + 1;
    localparam int RW     = DW + 1;
    localparam int SW     = PW + 3;
    localparam int ITER_W = $clog2(ANGLE_BITS);
    localparam int SHIFT  = 24 + owo_pkg::GUARD - POS_FRAC_BITS;
    localparam int LIM_EXP = PW - 32 + SHIFT;

    localparam logic [63:0]            PHI_LIM = 64'd1 << LIM_EXP;
    localparam logic [DW-1:0]          MAG_LIM = {1'b1, {PW{1'b0}}};
    localparam logic signed [PW-1:0]   POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0]   POS_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic [ITER_W-1:0]      ITER_LAST = ITER_W'(ANGLE_BITS - 1);

    // multiplier schedule: bits [2:1] of the step pick the operation
    localparam logic [1:0] K_LO_INV  = 2'd0;
    localparam logic [1:0] K_HI_INV  = 2'd1;
    localparam logic [1:0] K_LO_GAIN = 2'd2;
    localparam logic [1:0] K_HI_GAIN = 2'd3;
    localparam logic [3:0] MSTEP_LAST = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROT,
        ST_ABS,
        ST_MUL,
        ST_ACC
    } state_t;

    state_t                   state_reg;
    logic [31:0]              gain_reg;
    logic signed [PW-1:0]     acc_x_reg;
    logic signed [PW-1:0]     acc_y_reg;
    logic [CW-1:0]            prev_reg [4];
    logic signed [CW-1:0]     d_reg [4];
    logic [HW-1:0]            hd_reg;
    logic                     flip_reg;
    logic signed [XW-1:0]     x_reg;
    logic signed [XW-1:0]     y_reg;
    logic signed [ZW-1:0]     z_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [MW-1:0]            mx_reg;
    logic [MW-1:0]            my_reg;
    logic                     sx_reg;
    logic                     sy_reg;
    logic [3:0]               mstep_reg;
    logic [63:0]              prod_reg;
    logic [TW-1:0]            tx_reg;
    logic [TW-1:0]            ty_reg;
    logic [DW-1:0]            dmx_reg;
    logic [DW-1:0]            dmy_reg;
    logic                     m_tvalid_reg;
    logic [owo_pkg::OUT_W-1:0] m_tdata_reg;

    logic                     accept;
    logic                     out_free;
    logic [HW-1:0]            hd_in;
    logic                     flip_in;
    logic signed [31:0]       ang_in;
    logic signed [XW-1:0]     e0, e1, e2, e3;
    logic signed [XW-1:0]     u_sc, v_sc;
    logic signed [XW-1:0]     x_sh, y_sh;
    logic signed [XW-1:0]     x_rot, y_rot;
    logic signed [ZW-1:0]     z_rot;
    logic signed [ZW-1:0]     atan_z;
    logic signed [XW-1:0]     x_abs, y_abs;
    logic                     axis_i, axis_c;
    logic [1:0]               kind_i, kind_c;
    logic [3:0]               pstep;
    logic [MW-1:0]            m_sel;
    logic [31:0]              a_op, b_op;
    logic [63:0]              prod_next;
    logic [TW-1:0]            t_sel;
    logic [MW-1:0]            m1;
    logic [TW-1:0]            t_lo, t_sh;
    logic [63:0]              phi_sh;
    logic [RW-1:0]            r_sum;
    logic [DW-1:0]            dmag;
    logic signed [SW-1:0]     dx_s, dy_s;
    logic signed [SW-1:0]     sum_x, sum_y;
    logic signed [PW-1:0]     sat_x, sat_y;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    // take register writes only between items
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // heading in [90, 270) degrees: rotate by 180 first
    assign hd_in   = s_tdata[4*CW +: HW];
    assign flip_in = hd_in[HW-1] ^ hd_in[HW-2];
    assign ang_in  = {hd_in[HW-1] ^ flip_in, hd_in[HW-2:0], 16'b0};

    always_comb begin
        e0   = XW'(d_reg[0]);
        e1   = XW'(d_reg[1]);
        e2   = XW'(d_reg[2]);
        e3   = XW'(d_reg[3]);
        u_sc = (e2 + e3 - e0 - e1) <<< owo_pkg::GUARD;
        v_sc = (e0 + e3 - e1 - e2) <<< owo_pkg::GUARD;
    end

    // one CORDIC pass, shift picked by the iteration count
    always_comb begin
        x_sh   = x_reg >>> iter_reg;
        y_sh   = y_reg >>> iter_reg;
        atan_z = $signed(ZW'(owo_pkg::atan_angle(5'(iter_reg))));
        if (!z_reg[ZW-1]) begin
            x_rot = x_reg - y_sh;
            y_rot = y_reg + x_sh;
            z_rot = z_reg - atan_z;
        end else begin
            x_rot = x_reg + y_sh;
            y_rot = y_reg - x_sh;
            z_rot = z_reg + atan_z;
        end
    end

    assign x_abs = x_reg[XW-1] ? -x_reg : x_reg;
    assign y_abs = y_reg[XW-1] ? -y_reg : y_reg;

    // shared multiplier: issue side
    always_comb begin
        axis_i    = mstep_reg[0];
        kind_i    = mstep_reg[2:1];
        m_sel     = axis_i ? my_reg : mx_reg;
        a_op      = (kind_i == K_HI_INV || kind_i == K_HI_GAIN) ?
                    32'(m_sel[MW-1:32]) : m_sel[31:0];
        b_op      = (kind_i == K_LO_GAIN || kind_i == K_HI_GAIN) ?
                    gain_reg : owo_pkg::INV_K;
        prod_next = 64'(a_op) * 64'(b_op);
    end

    // shared multiplier: consume side, one step behind
    always_comb begin
        pstep  = mstep_reg - 4'd1;
        axis_c = pstep[0];
        kind_c = pstep[2:1];
        t_sel  = axis_c ? ty_reg : tx_reg;
        t_lo   = TW'(prod_reg[63:32]);
        t_sh   = TW'(prod_reg >> SHIFT);
        m1     = prod_reg[MW-1:0] + MW'(t_sel);
        phi_sh = prod_reg << (32 - SHIFT);
        r_sum  = RW'(phi_sh) + RW'(t_sel);
        if (prod_reg >= PHI_LIM || r_sum > RW'(MAG_LIM)) begin
            dmag = MAG_LIM;
        end else begin
            dmag = r_sum[DW-1:0];
        end
    end

    // signed step and saturating accumulate
    always_comb begin
        dx_s  = sx_reg ? -$signed({2'b00, dmx_reg}) : $signed({2'b00, dmx_reg});
        dy_s  = sy_reg ? -$signed({2'b00, dmy_reg}) : $signed({2'b00, dmy_reg});
        sum_x = SW'(acc_x_reg) + dx_s;
        sum_y = SW'(acc_y_reg) + dy_s;
        if (sum_x > SW'(POS_MAX)) begin
            sat_x = POS_MAX;
        end else if (sum_x < SW'(POS_MIN)) begin
            sat_x = POS_MIN;
        end else begin
            sat_x = sum_x[PW-1:0];
        end
        if (sum_y > SW'(POS_MAX)) begin
            sat_y = POS_MAX;
        end else if (sum_y < SW'(POS_MIN)) begin
            sat_y = POS_MIN;
        end else begin
            sat_y = sum_y[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            gain_reg     <= owo_pkg::GAIN_RESET;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            // the accumulate step reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_ACC) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        for (int i = 0; i < 4; i++) begin
                            d_reg[i]    <= s_tdata[i*CW +: CW] - prev_reg[i];
                            prev_reg[i] <= s_tdata[i*CW +: CW];
                        end
                        hd_reg    <= hd_in;
                        flip_reg  <= flip_in;
                        z_reg     <= ZW'(ang_in);
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    x_reg     <= flip_reg ? -u_sc : u_sc;
                    y_reg     <= flip_reg ? -v_sc : v_sc;
                    iter_reg  <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    x_reg    <= x_rot;
                    y_reg    <= y_rot;
                    z_reg    <= z_rot;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    mx_reg    <= x_abs[MW-1:0];
                    my_reg    <= y_abs[MW-1:0];
                    sx_reg    <= x_reg[XW-1];
                    sy_reg    <= y_reg[XW-1];
                    mstep_reg <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (mstep_reg != MSTEP_LAST) begin
                        prod_reg <= prod_next;
                    end
                    if (mstep_reg != '0) begin
                        case (kind_c)
                            K_LO_INV: begin
                                if (axis_c) ty_reg <= t_lo;
                                else        tx_reg <= t_lo;
                            end
                            K_HI_INV: begin
                                if (axis_c) my_reg <= m1;
                                else        mx_reg <= m1;
                            end
                            K_LO_GAIN: begin
                                if (axis_c) ty_reg <= t_sh;
                                else        tx_reg <= t_sh;
                            end
                            K_HI_GAIN: begin
                                if (axis_c) dmy_reg <= dmag;
                                else        dmx_reg <= dmag;
                            end
                            default: ;
                        endcase
                    end
                    mstep_reg <= mstep_reg + 4'd1;
                    if (mstep_reg == MSTEP_LAST) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    // hold until the output register is free
                    if (out_free) begin
                        acc_x_reg    <= sat_x;
                        acc_y_reg    <= sat_y;
                        m_tdata_reg  <= {hd_reg, sat_y, sat_x};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    owo_pkg::CFG_GAIN:    gain_reg  <= cfg_data[owo_pkg::GAIN_W-1:0];
                    owo_pkg::CFG_START_X: acc_x_reg <= cfg_data[PW-1:0];
                    owo_pkg::CFG_START_Y: acc_y_reg <= cfg_data[PW-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/owo_checker.sv -----
// ----------------------------------------------------------------------------
// owo_checker
// Port-level checks on the odometry block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "omni_wheel_odometry_top_defines.svh"

module owo_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [owo_pkg::OUT_W-1:0]     m_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    // a stalled result word holds
    `OWO_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one word at a time: busy right after an accept
    `OWO_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready right after accept")

    // accepting a word never disturbs the pending result
    `OWO_ASSERT_NXT(a_accept_keeps_out, aclk, aresetn, s_tvalid && s_tready, $stable(m_tdata), "result data moved on input accept")

    // a new result only comes out of a busy engine
    `OWO_ASSERT_IMP(a_result_from_work, aclk, aresetn, $rose(m_tvalid), !$past(s_tready), "result appeared without work")

endmodule

bind omni_wheel_odometry_top owo_checker u_owo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

// ----- test/tb_omni_wheel_odometry_top.sv -----
// ----------------------------------------------------------------------------
// tb_omni_wheel_odometry_top
// Self-checking bench for the X-drive omni wheel odometry block. Streams
// encoder count and heading words through the slave port and predicts every
// pose word from a bit-true model of the CORDIC rotation, gain and saturating
// accumulate. The gain and start registers are changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_omni_wheel_odometry_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W  = owo_pkg::IN_W;
    localparam int OUT_W = owo_pkg::OUT_W;
    localparam int POS_W = owo_pkg::POS_W;
    localparam int HDG_W = owo_pkg::HDG_W;
    localparam int CNT_W = owo_pkg::CNT_W;

    localparam int ROT_STEPS  = (owo_pkg::ANGLE_BITS_DEF > 24) ? 24 : owo_pkg::ANGLE_BITS_DEF;
    localparam int FRAC_GUARD = 16;
    localparam int GAIN_SHIFT = 24 + FRAC_GUARD - owo_pkg::POS_FRAC_BITS_DEF;
    localparam logic [31:0]  CORDIC_INV_GAIN = 32'd2608131496;
    localparam longint       POS_TOP    = (longint'(1) <<< 47) - 1;
    localparam longint       POS_BOTTOM = -POS_TOP - 1;
    localparam logic [127:0] STEP_CAP   = 128'h1 << 48;
    localparam logic [127:0] NO_CAP     = '1;
    localparam logic [owo_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = owo_pkg::ANGLE_BITS_DEF + 13 + 12;

    typedef struct {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [HDG_W-1:0] hdg;
    } pose_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    // wheel1_count, wheel2_count, wheel3_count, wheel4_count, heading
    logic [IN_W-1:0]                   s_tdata   = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    // position_x, position_y, heading_out
    logic [OUT_W-1:0]                  m_tdata;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [owo_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [owo_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

    omni_wheel_odometry_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    logic [31:0] arctan_step [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // predicted block state
    logic [31:0] wheel_prev [4] = '{32'd0, 32'd0, 32'd0, 32'd0};
    longint      pose_x   = 0;
    longint      pose_y   = 0;
    logic [31:0] gain_reg = owo_pkg::GAIN_RESET;

    logic [IN_W-1:0] pending_words [$];
    pose_t           expected_pose [$];

    int words_waiting = 0;
    int words_sent    = 0;
    int poses_checked = 0;
    int reg_writes    = 0;
    int fail_count    = 0;

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int send_wait = 0;
    int hold_left = 0;
    bit hold_armed = 1'b0;

    // stimulus-side copy of the last counts and heading queued
    logic [31:0] cur_count [4] = '{32'd0, 32'd0, 32'd0, 32'd0};
    logic [15:0] last_heading = 16'h0000;

    // magnitude * f >> sh, capped, sign restored (truncates toward zero)
    function automatic longint scale_toward_zero(input longint v, input logic [31:0] f,
                                                 input int sh, input logic [127:0] cap);
        logic [127:0] wide;
        wide = (v < 0) ? -v : v;
        wide = (wide * f) >> sh;
        if (wide > cap)
            wide = cap;
        return (v < 0) ? -longint'(wide[63:0]) : longint'(wide[63:0]);
    endfunction

    function automatic longint clamp_add(input longint acc, input longint step);
        longint s;
        s = acc + step;
        if (s > POS_TOP)
            s = POS_TOP;
        if (s < POS_BOTTOM)
            s = POS_BOTTOM;
        return s;
    endfunction

    function automatic pose_t advance_pose(input logic [IN_W-1:0] word);
        pose_t       p;
        logic [31:0] cnt;
        logic [31:0] ang;
        logic [15:0] hd;
        longint      d [4];
        longint      ux, vy, z, nx, ny, dx, dy;
        int          k;
        hd = word[4*CNT_W +: HDG_W];
        for (k = 0; k < 4; k++) begin
            cnt = word[k*CNT_W +: CNT_W];
            d[k] = longint'(int'(cnt - wheel_prev[k]));
            wheel_prev[k] = cnt;
        end
        ux = (-d[0] - d[1] + d[2] + d[3]) <<< FRAC_GUARD;
        vy = (d[0] - d[1] - d[2] + d[3]) <<< FRAC_GUARD;

        // fold the left half-plane onto the right one
        ang = {hd, 16'h0000};
        if (ang >= 32'h4000_0000 && ang < 32'hC000_0000) begin
            ux = -ux;
            vy = -vy;
            ang = ang - 32'h8000_0000;
        end
        z = longint'(int'(ang));

        for (k = 0; k < ROT_STEPS; k++) begin
            if (z >= 0) begin
                nx = ux - (vy >>> k);
                ny = vy + (ux >>> k);
                z  = z - longint'(arctan_step[k]);
            end else begin
                nx = ux + (vy >>> k);
                ny = vy - (ux >>> k);
                z  = z + longint'(arctan_step[k]);
            end
            ux = nx;
            vy = ny;
        end

        ux = scale_toward_zero(ux, CORDIC_INV_GAIN, 32, NO_CAP);
        vy = scale_toward_zero(vy, CORDIC_INV_GAIN, 32, NO_CAP);
        dx = scale_toward_zero(ux, gain_reg, GAIN_SHIFT, STEP_CAP);
        dy = scale_toward_zero(vy, gain_reg, GAIN_SHIFT, STEP_CAP);
        pose_x = clamp_add(pose_x, dx);
        pose_y = clamp_add(pose_y, dy);

        p.pos_x = pose_x[POS_W-1:0];
        p.pos_y = pose_y[POS_W-1:0];
        p.hdg   = hd;
        return p;
    endfunction

    // Driver: present queued words, with a drawn gap after each one while send_idle is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_wait > 0) begin
                s_tvalid  <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending_words.size() > 0) begin
                s_tdata   <= pending_words.pop_front();
                s_tvalid  <= 1'b1;
                send_wait <= send_idle ? int'($urandom_range(0, 11)) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: when idling, hold each result word for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_armed <= 1'b0;
            hold_left  <= 0;
        end else if (!recv_idle) begin
            m_tready <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            m_tready   <= 1'b0;
            hold_armed <= 1'b0;
        end else if (m_tvalid) begin
            if (!hold_armed) begin
                hold_armed <= 1'b1;
                hold_left  <= int'($urandom_range(0, 11));
            end else if (hold_left == 0) begin
                m_tready <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Monitor: track register writes, predict accepted words, check results
    always @(posedge aclk) begin
        pose_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_index)
                    owo_pkg::CFG_GAIN:    gain_reg = cfg_data[31:0];
                    owo_pkg::CFG_START_X: pose_x = longint'($signed(cfg_data));
                    owo_pkg::CFG_START_Y: pose_y = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_pose.size() == 0) begin
                    $display("%0t: result word with nothing expected, expected none actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_pose.pop_front();
                    poses_checked++;
                    if (m_tdata[0 +: POS_W] !== want.pos_x) begin
                        $display("%0t: position_x expected %h actual %h",
                                 $time, want.pos_x, m_tdata[0 +: POS_W]);
                        fail_count++;
                    end
                    if (m_tdata[POS_W +: POS_W] !== want.pos_y) begin
                        $display("%0t: position_y expected %h actual %h",
                                 $time, want.pos_y, m_tdata[POS_W +: POS_W]);
                        fail_count++;
                    end
                    if (m_tdata[2*POS_W +: HDG_W] !== want.hdg) begin
                        $display("%0t: heading_out expected %h actual %h",
                                 $time, want.hdg, m_tdata[2*POS_W +: HDG_W]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pose.push_back(advance_pose(s_tdata));
                words_waiting--;
                words_sent++;
            end
        end
    end

    task automatic queue_word(input logic [31:0] w1, input logic [31:0] w2,
                              input logic [31:0] w3, input logic [31:0] w4,
                              input logic [15:0] hd);
        pending_words.push_back({hd, w4, w3, w2, w1});
        words_waiting++;
        cur_count[0] = w1;
        cur_count[1] = w2;
        cur_count[2] = w3;
        cur_count[3] = w4;
        last_heading = hd;
    endtask

    task automatic queue_moves(input logic [31:0] d1, input logic [31:0] d2,
                               input logic [31:0] d3, input logic [31:0] d4,
                               input logic [15:0] hd);
        queue_word(cur_count[0] + d1, cur_count[1] + d2,
                   cur_count[2] + d3, cur_count[3] + d4, hd);
    endtask

    // hold until every word is out and the pipeline has drained
    task automatic drain();
        while (words_waiting != 0 || expected_pose.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [owo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [owo_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [47:0] pick_start();
        logic [47:0] v;
        case ($urandom_range(0, 3))
            0: v = 48'h0;
            1: v = {16'($urandom), 32'($urandom)};
            2: v = 48'($signed(32'($urandom)));
            default: v = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
        endcase
        return v;
    endfunction

    initial begin
        int          p, n, r, k;
        logic [31:0] dw [4];
        logic [31:0] g;
        logic [15:0] hd;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: quadrant edges, count wrap, first step against zero
        queue_word(32'd0, 32'd0, 32'd0, 32'd0, 16'h0000);
        queue_moves(0, 0, 1000, 1000, 16'h0000);
        queue_moves(0, 0, 1000, 1000, 16'h4000);
        queue_moves(0, 0, 1000, 1000, 16'h3FFF);
        queue_moves(0, 0, 1000, 1000, 16'h8000);
        queue_moves(0, 0, 1000, 1000, 16'h7FFF);
        queue_moves(0, 0, 1000, 1000, 16'hC000);
        queue_moves(0, 0, 1000, 1000, 16'hBFFF);
        queue_moves(500, 0, 0, 500, 16'h2000);
        queue_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234);
        queue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hEDCC);
        drain();

        // full gain from the position extremes: drive both axes into saturation
        write_reg(owo_pkg::CFG_GAIN, 48'h0000_FFFF_FFFF);
        write_reg(owo_pkg::CFG_START_X, 48'h7FFF_FFFF_FFFF);
        write_reg(owo_pkg::CFG_START_Y, 48'h8000_0000_0000);
        write_reg(CFG_SPARE, {16'($urandom), 32'($urandom)});
        queue_moves(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
        queue_moves(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h0000);
        queue_moves(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h8000);
        queue_moves(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000);
        queue_moves(1, 0, 0, 1, 16'h0000);
        queue_moves(0, 0, 0, 0, 16'hFFFF);
        drain();

        // zero gain: position must not move
        write_reg(owo_pkg::CFG_GAIN, 48'h0);
        write_reg(owo_pkg::CFG_START_X, 48'h8000_0000_0000);
        write_reg(owo_pkg::CFG_START_Y, 48'h7FFF_FFFF_FFFF);
        for (n = 0; n < 3; n++)
            queue_word($urandom, $urandom, $urandom, $urandom, 16'($urandom));

        // random phases, mostly smooth motion with some jumps and noise
        for (p = 0; p < 6; p++) begin
            drain();
            case ($urandom_range(0, 3))
                0: g = $urandom;
                1: g = $urandom_range(32'h0040_0000, 32'h0400_0000);
                2: g = owo_pkg::GAIN_RESET;
                default: g = $urandom_range(0, 255);
            endcase
            write_reg(owo_pkg::CFG_GAIN, {16'h0, g});
            write_reg(owo_pkg::CFG_START_X, pick_start());
            write_reg(owo_pkg::CFG_START_Y, pick_start());
            send_idle = (p != 0 && p != 3);
            recv_idle = (p != 0 && p != 2);
            for (n = 0; n < 200; n++) begin
                r = $urandom_range(0, 99);
                for (k = 0; k < 4; k++) begin
                    if (r < 78)
                        dw[k] = cur_count[k] + $urandom_range(0, 4000) - 2000;
                    else if (r < 86)
                        dw[k] = $urandom;
                    else if (r < 93)
                        dw[k] = cur_count[k] +
                                ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
                    else
                        dw[k] = cur_count[k];
                end
                if (r < 78)
                    hd = last_heading + 16'($urandom_range(0, 2048)) - 16'd1024;
                else
                    hd = 16'($urandom);
                queue_word(dw[0], dw[1], dw[2], dw[3], hd);
            end
        end
        drain();

        $display("Streamed %0d count words and checked %0d poses over %0d register writes.",
                 words_sent, poses_checked, reg_writes);
        $display("Covered quadrant edges, count wrap, gain extremes and position saturation.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
